// ===== rtl/ftrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrs_pkg: shared widths, types and tables
// Constants and pipeline sideband types for the face target rotation steer.
// ----------------------------------------------------------------------------
package ftrs_pkg;

    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int RATE_W   = 24;
    localparam int LIM_W    = RATE_W - 1;
    localparam int CFG_W    = 15;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CORDIC_N = 16;
    localparam int GUARD_SH = 8;
    localparam int CXW      = DIFF_W + GUARD_SH + 4;
    localparam int ZW       = 32;
    localparam int SIZE_W   = ANGLE_W + 1;
    localparam int PROD_W   = LIM_W + SIZE_W;
    localparam int QW       = LIM_W;
    localparam int ACC_W    = RATE_W + 5;
    localparam int IN_W     = 128;
    localparam int OUT_W    = 2 * RATE_W;

    typedef enum logic {
        CFG_ALIGN = 1'b0,
        CFG_SLOW  = 1'b1
    } t_cfg_idx;

    // sideband carried alongside the CORDIC
    typedef struct packed {
        logic [ANGLE_W-1:0]       facing;
        logic signed [RATE_W-1:0] rate;
        logic [LIM_W-1:0]         limit;
    } t_side;

    // sideband carried alongside the divider
    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [LIM_W-1:0]         limit;
        logic                     aligned;
        logic                     big;
        logic                     zero;
        logic                     neg;
    } t_dside;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [ZW-1:0] f_atan(input int i);
        logic [ZW-1:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ftrs_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrs_cordic: pipelined vectoring CORDIC
// atan2(dy, dx) in 2^-32 turn, one pre-rotation stage and one stage per
// iteration.
// ----------------------------------------------------------------------------
module ftrs_cordic
    import ftrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    input  t_side                    i_side,
    output logic                     o_vld,
    output logic [ZW-1:0]            o_z,
    output t_side                    o_side
);

    logic                  r_vld [0:CORDIC_N];
    logic                  r_zf  [0:CORDIC_N];
    logic signed [CXW-1:0] r_x   [0:CORDIC_N];
    logic signed [CXW-1:0] r_y   [0:CORDIC_N];
    logic [ZW-1:0]         r_z   [0:CORDIC_N];
    t_side                 r_sd  [0:CORDIC_N];

    logic signed [CXW-1:0] w_x;
    logic signed [CXW-1:0] w_y;

    assign w_x = CXW'(i_dx) <<< GUARD_SH;
    assign w_y = CXW'(i_dy) <<< GUARD_SH;

    // left half plane: rotate by a half turn first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            r_zf[0]  <= (i_dx == '0) && (i_dy == '0);
            r_sd[0]  <= i_side;
            if (w_x < 0) begin
                r_x[0] <= -w_x;
                r_y[0] <= -w_y;
                r_z[0] <= {1'b1, {(ZW-1){1'b0}}};
            end else begin
                r_x[0] <= w_x;
                r_y[0] <= w_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
                r_zf[g+1]  <= r_zf[g];
                r_sd[g+1]  <= r_sd[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + f_atan(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - f_atan(g);
                end
            end
        end
    end

    assign o_vld  = r_vld[CORDIC_N];
    assign o_z    = r_zf[CORDIC_N] ? '0 : r_z[CORDIC_N];
    assign o_side = r_sd[CORDIC_N];

endmodule

// ===== rtl/ftrs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrs_div: pipelined restoring divider
// One quotient bit per stage, MSB first. Quotient is exact while it fits QW
// bits; larger cases are flagged upstream and ignored.
// ----------------------------------------------------------------------------
module ftrs_div
    import ftrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [PROD_W-1:0] i_num,
    input  logic [CFG_W-1:0]  i_den,
    input  t_dside            i_side,
    output logic              o_vld,
    output logic [QW-1:0]     o_q,
    output t_dside            o_side
);

    logic              r_vld [0:QW];
    logic [PROD_W-1:0] r_rem [0:QW];
    logic [QW-1:0]     r_q   [0:QW];
    t_dside            r_sd  [0:QW];

    always_comb begin
        r_vld[0] = i_vld;
        r_rem[0] = i_num;
        r_q[0]   = '0;
        r_sd[0]  = i_side;
    end

    for (genvar g = 0; g < QW; g++) begin : g_st
        logic [PROD_W-1:0] w_dsh;
        assign w_dsh = PROD_W'(i_den) << (QW - 1 - g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
                r_sd[g+1]  <= r_sd[g];
                if (r_rem[g] >= w_dsh) begin
                    r_rem[g+1] <= r_rem[g] - w_dsh;
                    r_q[g+1]   <= r_q[g] | (QW'(1) << (QW - 1 - g));
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_q[g+1]   <= r_q[g];
                end
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_q    = r_q[QW];
    assign o_side = r_sd[QW];

endmodule

// ===== rtl/face_target_rotation_steer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_target_rotation_steer_unit: rotation steering toward a target point
// Bearing by CORDIC, wrapped heading error, scaled goal rate, saturated
// rotational acceleration.
// ----------------------------------------------------------------------------
// Fully pipelined: one word accepted per clock unless the output stalls;
// input register, 17 CORDIC stages, error and product stages, 23 divider
// stages, acceleration and output stages. The whole pipe advances together
// whenever the output register is empty or its word is being taken. The user
// must write align_radius and slow_radius through the config channel only
// while the pipe is empty (unchecked here); config writes are always ready.
module face_target_rotation_steer_unit
    import ftrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // pos_x[15:0] pos_y[31:16] target_x[47:32] target_y[63:48]
    // facing[79:64] rot_rate[103:80] acc_limit[126:104] zero[127]
    input  logic [IN_W-1:0]    i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // rot_accel[23:0] rate_out[47:24]
    output logic [OUT_W-1:0]   o_m_tdata,
    // aligned[0]
    output logic               o_m_tuser,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic             w_en;
    logic [CFG_W-1:0] r_align;
    logic [CFG_W-1:0] r_slow;

    assign w_en        = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= CFG_W'(546);
            r_slow  <= CFG_W'(5461);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ALIGN: r_align <= i_cfg_data;
                CFG_SLOW:  r_slow  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // input stage: coordinate differences
    logic signed [COORD_W-1:0] w_px, w_py, w_tx, w_ty;
    logic                      r_a_vld;
    logic signed [DIFF_W-1:0]  r_a_dx, r_a_dy;
    t_side                     r_a_sd;

    assign w_px = i_s_tdata[15:0];
    assign w_py = i_s_tdata[31:16];
    assign w_tx = i_s_tdata[47:32];
    assign w_ty = i_s_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld       <= i_s_tvalid;
            r_a_dx        <= DIFF_W'(w_tx) - DIFF_W'(w_px);
            r_a_dy        <= DIFF_W'(w_ty) - DIFF_W'(w_py);
            r_a_sd.facing <= i_s_tdata[79:64];
            r_a_sd.rate   <= i_s_tdata[103:80];
            r_a_sd.limit  <= i_s_tdata[126:104];
        end
    end

    logic          c_vld;
    logic [ZW-1:0] c_z;
    t_side         c_sd;

    ftrs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_a_vld),
        .i_dx    (r_a_dx),
        .i_dy    (r_a_dy),
        .i_side  (r_a_sd),
        .o_vld   (c_vld),
        .o_z     (c_z),
        .o_side  (c_sd)
    );

    // heading error: round bearing, add a quarter turn, wrap
    logic [ZW:0]                n_zr;
    logic [ANGLE_W-1:0]         n_bear;
    logic signed [ANGLE_W-1:0]  n_err;
    logic                       r_b_vld;
    logic [SIZE_W-1:0]          r_b_size;
    logic                       r_b_neg;
    logic signed [RATE_W-1:0]   r_b_rate;
    logic [LIM_W-1:0]           r_b_limit;

    always_comb begin
        n_zr   = {1'b0, c_z} + (ZW+1)'(1 << (ZW - 1 - ANGLE_W));
        n_bear = n_zr[ZW-1 -: ANGLE_W] + ANGLE_W'(1 << (ANGLE_W - 2));
        n_err  = n_bear - c_sd.facing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld   <= c_vld;
            r_b_neg   <= n_err[ANGLE_W-1];
            r_b_size  <= n_err[ANGLE_W-1] ? -SIZE_W'(n_err) : SIZE_W'(n_err);
            r_b_rate  <= c_sd.rate;
            r_b_limit <= c_sd.limit;
        end
    end

    // classification and limit * |err|
    logic              r_c_vld;
    logic [PROD_W-1:0] r_c_prod;
    t_dside            r_c_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld        <= r_b_vld;
            r_c_prod       <= PROD_W'(r_b_limit) * PROD_W'(r_b_size);
            r_c_sd.rate    <= r_b_rate;
            r_c_sd.limit   <= r_b_limit;
            r_c_sd.aligned <= r_b_size < SIZE_W'(r_align);
            r_c_sd.big     <= r_b_size > SIZE_W'(r_slow);
            r_c_sd.zero    <= r_b_size == '0;
            r_c_sd.neg     <= r_b_neg;
        end
    end

    logic          d_vld;
    logic [QW-1:0] d_q;
    t_dside        d_sd;

    ftrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_c_vld),
        .i_num   (r_c_prod),
        .i_den   (r_slow),
        .i_side  (r_c_sd),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_side  (d_sd)
    );

    // (goal - rate) * 10
    logic [LIM_W-1:0]         n_mag;
    logic signed [RATE_W:0]   n_goal;
    logic signed [RATE_W:0]   n_diff;
    logic                     r_e_vld;
    logic signed [ACC_W-1:0]  r_e_acc;
    t_dside                   r_e_sd;

    always_comb begin
        if (d_sd.zero) begin
            n_mag = '0;
        end else if (d_sd.big) begin
            n_mag = d_sd.limit;
        end else begin
            n_mag = d_q;
        end
        n_goal = d_sd.neg ? -(RATE_W+1)'(n_mag) : (RATE_W+1)'(n_mag);
        n_diff = n_goal - (RATE_W+1)'(d_sd.rate);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= d_vld;
            r_e_acc <= (ACC_W'(n_diff) <<< 3) + (ACC_W'(n_diff) <<< 1);
            r_e_sd  <= d_sd;
        end
    end

    // saturate and output register
    logic signed [ACC_W-1:0]  w_lim;
    logic signed [RATE_W-1:0] n_acc;
    logic                     r_o_vld;
    logic signed [RATE_W-1:0] r_o_acc;
    logic signed [RATE_W-1:0] r_o_rate;
    logic                     r_o_al;

    assign w_lim = ACC_W'(r_e_sd.limit);

    always_comb begin
        if (r_e_acc > w_lim) begin
            n_acc = RATE_W'(w_lim);
        end else if (r_e_acc < -w_lim) begin
            n_acc = RATE_W'(-w_lim);
        end else begin
            n_acc = RATE_W'(r_e_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld  <= r_e_vld;
            r_o_al   <= r_e_sd.aligned;
            r_o_acc  <= r_e_sd.aligned ? '0 : n_acc;
            r_o_rate <= r_e_sd.aligned ? '0 : r_e_sd.rate;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {r_o_rate, r_o_acc};
    assign o_m_tuser  = r_o_al;

    a_aligned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("aligned word with nonzero payload");

    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== bench/face_target_rotation_steer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_target_rotation_steer_checker: output predictor and scoreboard
// Watches the input, output and register channels, computes the expected
// steering word for every accepted input and compares it in order.
// ----------------------------------------------------------------------------
module face_target_rotation_steer_checker
    import ftrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,
    input  logic             i_m_tuser,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic signed [RATE_W-1:0] accel;
        logic signed [RATE_W-1:0] rate;
        logic                     aligned;
    } t_steer;

    t_steer steer_q[$];
    logic [CFG_W-1:0] align_r, slow_r;

    // floor shift, safe for negatives
    function automatic longint floor_shr(input longint v, input int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic logic [31:0] bearing_turns(input longint x0, input longint y0);
        longint x, y, xs, ys;
        logic [31:0] z;
        z = '0;
        x = x0 * 256;
        y = y0 * 256;
        if (x0 == 0 && y0 == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + f_atan(i);
            end else begin
                x = x - ys; y = y + xs; z = z - f_atan(i);
            end
        end
        return z;
    endfunction

    function automatic t_steer steer_predict(input logic [IN_W-1:0] d);
        t_steer r;
        longint dx, dy, rate, lim, err, mag, goal, acc;
        logic [31:0] z;
        logic [ANGLE_W-1:0] brg, e;
        dx = longint'($signed(d[47:32])) - longint'($signed(d[15:0]));
        dy = longint'($signed(d[63:48])) - longint'($signed(d[31:16]));
        rate = longint'($signed(d[103:80]));
        lim = longint'(d[126:104]);
        z = bearing_turns(dx, dy);
        brg = 16'((33'(z) + 33'(1 << 15)) >> 16) + 16'h4000;
        e = brg - d[79:64];
        err = longint'($signed(e));
        mag = err < 0 ? -err : err;
        if (mag < longint'(align_r)) begin
            r.accel = '0; r.rate = '0; r.aligned = 1'b1;
            return r;
        end
        if (mag == 0) goal = 0;
        else if (mag > longint'(slow_r)) goal = lim;
        else goal = (lim * mag) / longint'(slow_r);
        if (err < 0) goal = -goal;
        acc = (goal - rate) * 10;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        r.accel = acc[RATE_W-1:0];
        r.rate = rate[RATE_W-1:0];
        r.aligned = 1'b0;
        return r;
    endfunction

    assign o_pending = steer_q.size();

    always @(posedge i_clk) begin
        t_steer got, want;
        int nerr;
        nerr = 0;
        if (!i_rst_n) begin
            align_r <= 15'd546;
            slow_r <= 15'd5461;
            o_errors <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.accel = i_m_tdata[23:0];
                got.rate = i_m_tdata[47:24];
                got.aligned = i_m_tuser;
                if (steer_q.size() == 0) begin
                    $error("unexpected output word");
                    nerr = nerr + 1;
                end else begin
                    want = steer_q.pop_front();
                    if (got.accel !== want.accel) begin
                        $error("rot_accel: expected %0d actual %0d", want.accel, got.accel);
                        nerr = nerr + 1;
                    end
                    if (got.rate !== want.rate) begin
                        $error("rate_out: expected %0d actual %0d", want.rate, got.rate);
                        nerr = nerr + 1;
                    end
                    if (got.aligned !== want.aligned) begin
                        $error("aligned: expected %0d actual %0d", want.aligned,
                               got.aligned);
                        nerr = nerr + 1;
                    end
                end
            end
            o_errors <= o_errors + nerr;
            if (i_s_tvalid && i_s_tready) steer_q.push_back(steer_predict(i_s_tdata));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == CFG_ALIGN) align_r <= i_cfg_data;
                else slow_r <= i_cfg_data;
            end
        end
    end

endmodule

// ===== bench/face_target_rotation_steer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_target_rotation_steer_unit_tb: steering unit testbench
// Directed corner words then random agents over several radius settings,
// with random idle bursts on both stream sides; the checker scores outputs.
// ----------------------------------------------------------------------------
module face_target_rotation_steer_unit_tb;
    import ftrs_pkg::*;

    logic i_clk, i_rst_n;
    logic s_valid, s_ready, m_valid, m_ready, m_user;
    logic [IN_W-1:0] s_data;
    logic [OUT_W-1:0] m_data;
    logic cfg_valid, cfg_ready, cfg_addr;
    logic [CFG_W-1:0] cfg_data;
    int errors, pending;
    bit quiet;

    face_target_rotation_steer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    face_target_rotation_steer_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("face_target_rotation_steer_unit_tb: errors");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = int'($urandom_range(1, 14));
                m_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic agent_send(input logic signed [15:0] px, py, tx, ty,
                              input logic [15:0] fc, input logic [23:0] rr,
                              input logic [22:0] lim);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = int'($urandom_range(1, 14));
            s_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {1'b0, lim, rr, fc, ty, tx, py, px};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic agent_random();
        logic [15:0] px, py;
        px = 16'($urandom); py = 16'($urandom);
        case ($urandom_range(0, 3))
            0: agent_send(px, py, px + 16'($urandom_range(0, 64)) - 16'd32,
                          py + 16'($urandom_range(0, 64)) - 16'd32,
                          16'($urandom), 24'($urandom), 23'($urandom));
            1: agent_send(px, py, 16'($urandom), 16'($urandom), 16'($urandom),
                          24'($signed(12'($urandom))), 23'($urandom_range(0, 4000)));
            default: agent_send(px, py, 16'($urandom), 16'($urandom), 16'($urandom),
                                24'($urandom), 23'($urandom));
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        s_valid = 1'b0; s_data = '0; cfg_valid = 1'b0; cfg_addr = CFG_ALIGN;
        cfg_data = '0; quiet = 1'b0; i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed corners
        agent_send(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h4000, 24'd0, 23'd1000);
        agent_send(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'hC000, 24'd77, 23'h7FFFFF);
        agent_send(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'h0000,
                   24'h800000, 23'h7FFFFF);
        agent_send(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'hFFFF,
                   24'h7FFFFF, 23'd0);
        agent_send(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'hC000, 24'd0, 23'd500);
        agent_send(16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'h4000, -24'sd3, 23'd500);
        agent_send(16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'h1000, 24'd10, 23'd9999);
        agent_send(16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'h6000, 24'd5, 23'h7FFFFF);
        agent_send(16'sd0, 16'sd0, 16'sd30, 16'sd40, 16'h7000, -24'sd100, 23'd4000);
        drain();
        // zero radii: zero error unaligned, zero slow radius
        cfg_write(CFG_ALIGN, 15'd0);
        cfg_write(CFG_SLOW, 15'd0);
        agent_send(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h4000, 24'd20, 23'd300);
        agent_send(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'h4010, 24'd0, 23'd300);
        agent_send(16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'h0000, 24'd0, 23'd300);
        repeat (300) agent_random();
        drain();
        cfg_write(CFG_ALIGN, 15'h7FFF);
        cfg_write(CFG_SLOW, 15'd1);
        repeat (250) agent_random();
        drain();
        cfg_write(CFG_ALIGN, 15'd0);
        cfg_write(CFG_SLOW, 15'h7FFF);
        repeat (300) agent_random();
        drain();
        cfg_write(CFG_ALIGN, 15'($urandom_range(0, 2000)));
        cfg_write(CFG_SLOW, 15'($urandom_range(1, 32767)));
        repeat (350) agent_random();
        drain();
        cfg_write(CFG_ALIGN, 15'd546);
        cfg_write(CFG_SLOW, 15'd5461);
        repeat (200) agent_random();
        quiet = 1'b1;
        repeat (150) agent_random();
        drain();
        if (errors == 0) begin
            $display("face_target_rotation_steer_unit_tb: clean");
        end else begin
            $display("face_target_rotation_steer_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ftrs_pkg.sv
rtl/ftrs_cordic.sv
rtl/ftrs_div.sv
rtl/face_target_rotation_steer_unit.sv
bench/face_target_rotation_steer_checker.sv
bench/face_target_rotation_steer_unit_tb.sv
